### hw/rtl/i2ccds_pkg.sv
`timescale 1ns / 1ps

package i2ccds_pkg;

	localparam int unsigned RATE_W          = 23;
	localparam int unsigned CLK_W           = 32;
	localparam int unsigned HALF_W          = 4;
	localparam int unsigned PROD_W          = RATE_W + HALF_W + 1;
	localparam int unsigned DIVM1_W         = 16;
	localparam int unsigned HPM2_W          = 3;
	localparam int unsigned DIVIDER_MAX_DEF = 65536;

	localparam logic [HALF_W-1:0] HALF_FIRST = 4'd9;
	localparam logic [HALF_W-1:0] HALF_LAST  = 4'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic prod_calc;
		logic div_start;
		logic div_capture;
		logic mul_calc;
		logic eval;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic stop;
		logic last_half;
	} status_t;

endpackage

### hw/rtl/i2ccds_div.sv
`timescale 1ns / 1ps

module i2ccds_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [i2ccds_pkg::CLK_W-1:0]   dividend,
	input  logic [i2ccds_pkg::PROD_W-1:0]  divisor,
	output logic                           done,
	output logic [i2ccds_pkg::CLK_W-1:0]   quotient
);
	import i2ccds_pkg::*;

	localparam int unsigned CNT_W = $clog2(CLK_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CLK_W - 1);

	logic [PROD_W-1:0] rem_q;
	logic [CLK_W-1:0]  quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PROD_W:0]   shifted;
	logic [PROD_W:0]   divisor_ext;
	logic              fits;

	// restoring division, one quotient bit per cycle
	assign shifted     = {rem_q, quo_q[CLK_W-1]};
	assign divisor_ext = {1'b0, divisor};
	assign fits        = shifted >= divisor_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// the remainder stays below the divisor, so it fits in PROD_W bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? PROD_W'(shifted - divisor_ext) : shifted[PROD_W-1:0];
			quo_q <= {quo_q[CLK_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### hw/rtl/i2ccds_dp.sv
`timescale 1ns / 1ps

module i2ccds_dp #(
	parameter int unsigned DIVIDER_MAX = i2ccds_pkg::DIVIDER_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  i2ccds_pkg::cmd_t                cmd,
	output i2ccds_pkg::status_t             status,
	input  logic [i2ccds_pkg::RATE_W-1:0]   bit_rate,
	input  logic [i2ccds_pkg::CLK_W-1:0]    source_clock,
	output logic [i2ccds_pkg::DIVM1_W-1:0]  divider_minus_one,
	output logic [i2ccds_pkg::HPM2_W-1:0]   half_period_minus_two,
	output logic [i2ccds_pkg::CLK_W-1:0]    rate_error,
	output logic                            out_of_range
);
	import i2ccds_pkg::*;

	localparam int unsigned DIVW = $clog2(DIVIDER_MAX + 1);
	localparam logic [DIVW-1:0]  DIV_CAP   = DIVW'(DIVIDER_MAX);
	localparam logic [CLK_W-1:0] DIV_CAP_W = CLK_W'(DIVIDER_MAX);

	logic [RATE_W-1:0]         rate_q;
	logic [CLK_W-1:0]          clk_q;
	logic [HALF_W-1:0]         half_q;
	logic [PROD_W-1:0]         prod_q;
	logic [DIVW-1:0]           div_q;
	logic [CLK_W-1:0]          pd_q;
	logic [DIVW-1:0]           keep_div_q;
	logic [HALF_W-1:0]         keep_half_q;
	logic [CLK_W-1:0]          keep_err_q;
	logic [DIVM1_W-1:0]        divider_minus_one_q;
	logic [HPM2_W-1:0]         half_period_minus_two_q;
	logic [CLK_W-1:0]          rate_error_q;
	logic                      out_of_range_q;

	logic [RATE_W+HALF_W-1:0]  rate_half;
	logic [PROD_W+DIVW-1:0]    pd_full;
	logic [CLK_W-1:0]          quotient;
	logic                      div_done;
	logic [CLK_W-1:0]          err;
	logic                      take;

	i2ccds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (clk_q),
		.divisor  (prod_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign rate_half = rate_q * half_q;
	assign pd_full   = prod_q * div_q;
	// the achieved product never exceeds the source clock
	assign err       = clk_q - pd_q;
	assign take      = (err < keep_err_q) || (keep_err_q == '0);

	assign status.div_done  = div_done;
	assign status.stop      = (err == '0) || (div_q >= DIV_CAP);
	assign status.last_half = half_q == HALF_LAST;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rate_q     <= bit_rate;
			clk_q      <= source_clock;
			half_q     <= HALF_FIRST;
			keep_err_q <= '0;
		end
		if (cmd.prod_calc) begin
			prod_q <= {rate_half, 1'b0};
		end
		if (cmd.div_capture) begin
			// zero product counts as a saturated divider
			if (prod_q == '0 || quotient > DIV_CAP_W) begin
				div_q <= DIV_CAP;
			end else begin
				div_q <= quotient[DIVW-1:0];
			end
		end
		if (cmd.mul_calc) begin
			pd_q <= pd_full[CLK_W-1:0];
		end
		if (cmd.eval) begin
			half_q <= half_q - 1'b1;
			if (take) begin
				keep_div_q  <= div_q;
				keep_half_q <= half_q;
				keep_err_q  <= err;
			end
		end
		if (cmd.out_load) begin
			if (keep_div_q == '0) begin
				divider_minus_one_q <= '0;
				out_of_range_q      <= 1'b1;
			end else begin
				divider_minus_one_q <= DIVM1_W'(keep_div_q - 1'b1);
				out_of_range_q      <= 1'b0;
			end
			half_period_minus_two_q <= HPM2_W'(keep_half_q - HALF_LAST);
			rate_error_q            <= keep_err_q;
		end
	end

	assign divider_minus_one     = divider_minus_one_q;
	assign half_period_minus_two = half_period_minus_two_q;
	assign rate_error            = rate_error_q;
	assign out_of_range          = out_of_range_q;

	a_err_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> pd_q <= clk_q)
		else $error("achieved product exceeds source clock");

	a_half_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval |-> (half_q >= HALF_LAST) && (half_q <= HALF_FIRST))
		else $error("half length outside search range");

	a_div_capped: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_capture |=> div_q <= DIV_CAP)
		else $error("divider above cap");

endmodule

### hw/rtl/i2ccds_ctrl.sv
`timescale 1ns / 1ps

module i2ccds_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	output i2ccds_pkg::cmd_t     cmd,
	input  i2ccds_pkg::status_t  status
);
	import i2ccds_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE      = 7'b0000001,
		ST_PROD      = 7'b0000010,
		ST_DIV_START = 7'b0000100,
		ST_DIV_WAIT  = 7'b0001000,
		ST_MUL       = 7'b0010000,
		ST_EVAL      = 7'b0100000,
		ST_FINISH    = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   slot_free;

	// output register can take a new result when empty or being drained
	assign slot_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PROD;
				end
			end
			ST_PROD: begin
				cmd.prod_calc = 1'b1;
				state_d       = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (status.div_done) begin
					cmd.div_capture = 1'b1;
					state_d         = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_calc = 1'b1;
				state_d      = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (status.stop || status.last_half) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_PROD;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_PROD)
		else $error("accepted transaction did not start the search");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid)
		else $error("loaded result not presented");

	a_hold_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && out_stall) |=> state_q == ST_FINISH)
		else $error("result dropped while output stalled");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		status.div_done |-> state_q == ST_DIV_WAIT)
		else $error("divider finished outside wait state");

endmodule

### hw/rtl/i2c_clock_divider_search.sv
`timescale 1ns / 1ps

// channel  signals                                              direction
// input    in_valid, in_stall, bit_rate, source_clock           in (stall out)
// output   out_valid, out_stall, divider_minus_one,             out (stall in)
//          half_period_minus_two, rate_error, out_of_range
//
// each tried half length runs product, divider start, a pass through the shared
// bit-serial divider, capture, multiply, compare
// a transaction tries one to eight half lengths, from 9 down to 2
// arst_n clears the controller and output valid; no clearing pass
// a new transaction is taken while the previous result waits under out_stall

module i2c_clock_divider_search #(
	parameter int unsigned DIVIDER_MAX = i2ccds_pkg::DIVIDER_MAX_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [i2ccds_pkg::RATE_W-1:0]   bit_rate,
	input  logic [i2ccds_pkg::CLK_W-1:0]    source_clock,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [i2ccds_pkg::DIVM1_W-1:0]  divider_minus_one,
	output logic [i2ccds_pkg::HPM2_W-1:0]   half_period_minus_two,
	output logic [i2ccds_pkg::CLK_W-1:0]    rate_error,
	output logic                            out_of_range
);
	import i2ccds_pkg::*;

	cmd_t    cmd;
	status_t status;

	i2ccds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	i2ccds_dp #(
		.DIVIDER_MAX (DIVIDER_MAX)
	) u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.status                (status),
		.bit_rate              (bit_rate),
		.source_clock          (source_clock),
		.divider_minus_one     (divider_minus_one),
		.half_period_minus_two (half_period_minus_two),
		.rate_error            (rate_error),
		.out_of_range          (out_of_range)
	);

endmodule

### verif/i2c_clock_divider_search_test.sv
`timescale 1ns / 1ps

module i2c_clock_divider_search_test;

	import i2ccds_pkg::*;

	localparam longint unsigned DIV_CAP = DIVIDER_MAX_DEF;
	localparam int unsigned RANDOM_ITEMS = 2000;

	typedef struct packed {
		logic [DIVM1_W-1:0] divider_m1;
		logic [HPM2_W-1:0]  half_m2;
		logic [CLK_W-1:0]   rate_err;
		logic               unreachable;
	} divider_setting_t;

	typedef struct {
		logic [RATE_W-1:0] rate;
		logic [CLK_W-1:0]  sclk;
		bit                literal;
		divider_setting_t  want;
	} divider_case_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [RATE_W-1:0]   bit_rate = '0;
	logic [CLK_W-1:0]    source_clock = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DIVM1_W-1:0]  divider_minus_one;
	logic [HPM2_W-1:0]   half_period_minus_two;
	logic [CLK_W-1:0]    rate_error;
	logic                out_of_range;

	divider_setting_t pending_settings[$];
	int unsigned      mismatches = 0;
	int unsigned      settings_seen = 0;

	// expected rows: zero rate, zero clock, unreachable, capped, exact at first and last length
	divider_case_t divider_cases[$] = '{
		'{23'd0,       32'd0,          1'b1, '{16'd65535, 3'd7, 32'd0,          1'b0}},
		'{23'd0,       32'hFFFF_FFFF,  1'b1, '{16'd65535, 3'd7, 32'hFFFF_FFFF,  1'b0}},
		'{23'd1,       32'd0,          1'b1, '{16'd0,     3'd7, 32'd0,          1'b1}},
		'{23'h7F_FFFF, 32'd1,          1'b1, '{16'd0,     3'd7, 32'd1,          1'b1}},
		'{23'd1,       32'hFFFF_FFFF,  1'b1, '{16'd65535, 3'd7, 32'hFFED_FFFF,  1'b0}},
		'{23'd1,       32'd1179648,    1'b1, '{16'd65535, 3'd7, 32'd0,          1'b0}},
		'{23'd1,       32'd1179647,    1'b1, '{16'd65534, 3'd7, 32'd17,         1'b0}},
		'{23'd100000,  32'd1800000,    1'b1, '{16'd0,     3'd7, 32'd0,          1'b0}},
		'{23'd100000,  32'd400000,     1'b1, '{16'd0,     3'd0, 32'd0,          1'b0}},
		'{23'h7F_FFFF, 32'hFFFF_FFFF,  1'b0, '0},
		'{23'd5000000, 32'd48000000,   1'b0, '0},
		'{23'd5000000, 32'hFFFF_FFFF,  1'b0, '0},
		'{23'd400000,  32'd12000000,   1'b0, '0},
		'{23'd100000,  32'd12000000,   1'b0, '0},
		'{23'd100000,  32'd15000000,   1'b0, '0},
		'{23'd1000000, 32'd30000000,   1'b0, '0},
		'{23'd3400000, 32'd100000000,  1'b0, '0},
		'{23'd1,       32'd36,         1'b0, '0},
		'{23'd2,       32'd35,         1'b0, '0},
		'{23'd7,       32'd100,        1'b0, '0},
		'{23'd12345,   32'd2000000000, 1'b0, '0},
		'{23'h40_0000, 32'h8000_0000,  1'b0, '0},
		'{23'h2A_AAAA, 32'h5555_5555,  1'b0, '0},
		'{23'h55_5555, 32'hAAAA_AAAA,  1'b0, '0}
	};

	i2c_clock_divider_search dut (
		.clk                   (clk),
		.arst_n                (arst_n),
		.in_valid              (in_valid),
		.in_stall              (in_stall),
		.bit_rate              (bit_rate),
		.source_clock          (source_clock),
		.out_valid             (out_valid),
		.out_stall             (out_stall),
		.divider_minus_one     (divider_minus_one),
		.half_period_minus_two (half_period_minus_two),
		.rate_error            (rate_error),
		.out_of_range          (out_of_range)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic divider_setting_t predict_divider_search(input logic [RATE_W-1:0] rate,
			input logic [CLK_W-1:0] sclk);
		longint unsigned prod, div, err;
		longint unsigned keep_div, keep_err;
		int              keep_half;
		divider_setting_t res;
		keep_div  = 0;
		keep_err  = 0;
		keep_half = int'(HALF_FIRST);
		for (int h = int'(HALF_FIRST); h >= int'(HALF_LAST); h--) begin
			prod = longint'(rate) * longint'(h) * 2;
			// zero rate counts as a saturated divider
			if (prod == 0)
				div = DIV_CAP;
			else
				div = longint'(sclk) / prod;
			if (div > DIV_CAP)
				div = DIV_CAP;
			err = longint'(sclk) - prod * div;
			if (err < keep_err || keep_err == 0) begin
				keep_div  = div;
				keep_half = h;
				keep_err  = err;
			end
			if (err == 0 || div >= DIV_CAP)
				break;
		end
		res.unreachable = (keep_div == 0);
		res.divider_m1  = (keep_div == 0) ? '0 : DIVM1_W'(keep_div - 1);
		res.half_m2     = HPM2_W'(keep_half - int'(HALF_LAST));
		res.rate_err    = CLK_W'(keep_err);
		return res;
	endfunction

	bit sender_burst = 1'b0;

	// entered and left at a falling edge
	task automatic offer_request(input logic [RATE_W-1:0] rate, input logic [CLK_W-1:0] sclk,
			input divider_setting_t want);
		int unsigned gap;
		gap = sender_burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		bit_rate     <= rate;
		source_clock <= sclk;
		do @(posedge clk); while (in_stall);
		pending_settings.push_back(want);
		@(negedge clk);
	endtask

	task automatic pick_request(output logic [RATE_W-1:0] rate, output logic [CLK_W-1:0] sclk);
		longint unsigned exact;
		int unsigned     mode;
		mode = $urandom_range(0, 9);
		rate = RATE_W'($urandom_range(1, 5000000));
		sclk = $urandom;
		case (mode)
			0, 1, 2: sclk = $urandom_range(32'hFFFF_FFFF, 1000000);
			3, 4: begin
				// exact or near-exact product, so the search ends early or ties
				exact = longint'(rate) * $urandom_range(2, 9) * 2 * $urandom_range(1, 65536);
				exact = exact + $urandom_range(0, 4) - 2;
				if (exact <= 64'hFFFF_FFFF)
					sclk = CLK_W'(exact);
			end
			5, 6: begin
				rate = RATE_W'($urandom);
			end
			7: begin
				rate = RATE_W'($urandom_range(0, 2000));
				sclk = $urandom_range(0, 2000);
			end
			8: begin
				rate = RATE_W'($urandom_range(0, 300));
			end
			default: begin
				rate = RATE_W'($urandom_range(1000, 100));
				sclk = $urandom_range(100000000, 1000000);
			end
		endcase
	endtask

	initial begin
		logic [RATE_W-1:0] rate;
		logic [CLK_W-1:0]  sclk;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (divider_cases[i])
			offer_request(divider_cases[i].rate, divider_cases[i].sclk,
					divider_cases[i].literal ? divider_cases[i].want :
					predict_divider_search(divider_cases[i].rate, divider_cases[i].sclk));
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 64 == 0)
				sender_burst = ($urandom_range(0, 3) == 0);
			pick_request(rate, sclk);
			offer_request(rate, sclk, predict_divider_search(rate, sclk));
		end
		in_valid <= 1'b0;
		wait (pending_settings.size() == 0);
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("[i2c_clock_divider_search] OK");
		else
			$display("[i2c_clock_divider_search] ERROR");
		$finish;
	end

	initial begin
		divider_setting_t want;
		int unsigned      hold;
		bit               recv_burst;
		recv_burst = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (settings_seen % 64 == 0)
				recv_burst = ($urandom_range(0, 3) == 0);
			// long hold-off so the block backs up and stalls its input
			if (settings_seen % 700 == 100)
				hold = 2000;
			else
				hold = recv_burst ? 0 : $urandom_range(0, 5);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			settings_seen++;
			if (pending_settings.size() == 0) begin
				$display("%0t: unexpected transaction, got div %0d half %0d err %0d oor %0d",
						$time, divider_minus_one, half_period_minus_two, rate_error,
						out_of_range);
				mismatches++;
			end else begin
				want = pending_settings.pop_front();
				if (divider_minus_one !== want.divider_m1) begin
					$display("%0t: divider_minus_one expected %0d got %0d", $time,
							want.divider_m1, divider_minus_one);
					mismatches++;
				end
				if (half_period_minus_two !== want.half_m2) begin
					$display("%0t: half_period_minus_two expected %0d got %0d", $time,
							want.half_m2, half_period_minus_two);
					mismatches++;
				end
				if (rate_error !== want.rate_err) begin
					$display("%0t: rate_error expected %0d got %0d", $time,
							want.rate_err, rate_error);
					mismatches++;
				end
				if (out_of_range !== want.unreachable) begin
					$display("%0t: out_of_range expected %0d got %0d", $time,
							want.unreachable, out_of_range);
					mismatches++;
				end
			end
			@(negedge clk);
		end
	end

	initial begin
		#10_000_000;
		$display("[i2c_clock_divider_search] ERROR");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/i2ccds_pkg.sv
hw/rtl/i2ccds_div.sv
hw/rtl/i2ccds_dp.sv
hw/rtl/i2ccds_ctrl.sv
hw/rtl/i2c_clock_divider_search.sv
verif/i2c_clock_divider_search_test.sv
